### hdl/hms_clock_with_set_buttons_macros.svh
`ifndef HMS_CLOCK_WITH_SET_BUTTONS_MACROS_SVH
`define HMS_CLOCK_WITH_SET_BUTTONS_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define HMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hms check failed");

// Check that a condition implies another in the following cycle.
`define HMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hms check failed");

`endif

### hdl/hms_pkg.sv
package hms_pkg;

    // Register word indexes (paddr[3:2])
    localparam logic [1:0] REG_TICK_WHOLE_MS = 2'd0;
    localparam logic [1:0] REG_TICK_FRAC_US  = 2'd1;
    localparam logic [1:0] REG_MS_PER_SECOND = 2'd2;

    // Register reset values
    localparam logic [7:0]  TICK_WHOLE_MS_RST = 8'd8;
    localparam logic [9:0]  TICK_FRAC_US_RST  = 10'd192;
    localparam logic [15:0] MS_PER_SECOND_RST = 16'd1000;

    // Time constants
    localparam logic [10:0] US_PER_MS    = 11'd1000;
    localparam logic [10:0] US_TWO_MS    = 11'd2000;
    localparam logic [7:0]  SEC_PER_MIN  = 8'd60;
    localparam logic [7:0]  MIN_PER_HOUR = 8'd60;
    localparam logic [7:0]  HOUR_PER_DAY = 8'd24;
    localparam logic [2:0]  BUTTON_MASK  = 3'b111;

    // Decimal digit pair of one counter
    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } hms_digits_t;

endpackage

### hdl/hms_digits.sv
module hms_digits
    import hms_pkg::*;
(
    input  logic [7:0]  value,
    output hms_digits_t digits
);

    localparam logic [7:0] DIV10_MUL   = 8'd205;
    localparam int         DIV10_SHIFT = 11;
    localparam logic [7:0] TEN         = 8'd10;

    logic [15:0] prod_hi;
    logic [4:0]  quot_hi;
    logic [7:0]  ones_full;
    logic [12:0] prod_lo;
    logic [1:0]  quot_lo;
    logic [4:0]  tens_full;

    // Split value by ten using the reciprocal multiply
    always_comb
    begin
        prod_hi   = 16'(value) * 16'(DIV10_MUL);
        quot_hi   = 5'(prod_hi >> DIV10_SHIFT);
        ones_full = value - 8'(quot_hi) * TEN;
        prod_lo   = 13'(quot_hi) * 13'(DIV10_MUL);
        quot_lo   = 2'(prod_lo >> DIV10_SHIFT);
        tens_full = quot_hi - 5'(quot_lo) * 5'(TEN);
        digits.ones = ones_full[3:0];
        digits.tens = tens_full[3:0];
    end

endmodule

### hdl/hms_clock_with_set_buttons.sv
// Time-of-day clock (hh:mm:ss). Each input beat is either a timer tick
// (func = 0), which adds tick_whole_ms and tick_frac_us to the millisecond
// and microsecond accumulators, or a button sample (func = 1), which bumps
// seconds, minutes or hours when the low three bits differ from the last
// sample. After either, one second elapses when the millisecond count
// reaches ms_per_second. Every input beat yields exactly one result beat.
// An item is registered on accept and processed into the result register
// once the result slot is free, so the block takes one item per cycle;
// it stalls only while a result waits for out_ready.
// Registers sit on the APB port at byte addresses 0, 4 and 8.
`include "hms_clock_with_set_buttons_macros.svh"

module hms_clock_with_set_buttons
    import hms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [2:0]  buttons,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        second_elapsed,
    output logic [7:0]  hours,
    output logic [7:0]  minutes,
    output logic [7:0]  seconds,
    output logic [3:0]  hour_tens,
    output logic [3:0]  hour_ones,
    output logic [3:0]  minute_tens,
    output logic [3:0]  minute_ones,
    output logic [3:0]  second_tens,
    output logic [3:0]  second_ones
);

    logic [7:0]  tick_whole_ms_reg;
    logic [9:0]  tick_frac_us_reg;
    logic [15:0] ms_per_second_reg;

    logic        in_valid_reg;
    logic        func_reg;
    logic [2:0]  buttons_reg;

    logic [15:0] ms_accum_reg;
    logic [15:0] ms_accum_next;
    logic [9:0]  us_accum_reg;
    logic [9:0]  us_accum_next;
    logic [7:0]  sec_count_reg;
    logic [7:0]  sec_count_next;
    logic [7:0]  min_count_reg;
    logic [7:0]  min_count_next;
    logic [7:0]  hour_count_reg;
    logic [7:0]  hour_count_next;
    logic [2:0]  last_buttons_reg;
    logic [2:0]  last_buttons_next;
    logic        elapsed_next;

    logic        out_valid_reg;
    logic        elapsed_reg;
    logic [7:0]  hours_reg;
    logic [7:0]  minutes_reg;
    logic [7:0]  seconds_reg;

    logic        cfg_write;
    logic        fire;

    hms_digits_t hour_digits;
    hms_digits_t minute_digits;
    hms_digits_t second_digits;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TICK_WHOLE_MS: prdata = 32'(tick_whole_ms_reg);
            REG_TICK_FRAC_US:  prdata = 32'(tick_frac_us_reg);
            REG_MS_PER_SECOND: prdata = 32'(ms_per_second_reg);
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_whole_ms_reg <= TICK_WHOLE_MS_RST;
            tick_frac_us_reg  <= TICK_FRAC_US_RST;
            ms_per_second_reg <= MS_PER_SECOND_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_TICK_WHOLE_MS: tick_whole_ms_reg <= pwdata[7:0];
                REG_TICK_FRAC_US:  tick_frac_us_reg  <= pwdata[9:0];
                REG_MS_PER_SECOND: ms_per_second_reg <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    // Handshake: process the held beat when the result slot frees up
    assign fire      = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready  = ~in_valid_reg | fire;
    assign out_valid = out_valid_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid & in_ready)
        begin
            func_reg    <= func;
            buttons_reg <= buttons;
        end
    end

    // Next clock state for the held beat
    always_comb
    begin
        logic [10:0] us_sum;
        logic [9:0]  us_wrap;
        logic [1:0]  ms_carry;
        logic [16:0] ms_sum;
        logic [15:0] ms_base;
        logic [7:0]  sec_v;
        logic [7:0]  min_v;
        logic [7:0]  hour_v;
        logic [2:0]  btn;

        // Accumulate one tick
        us_sum = {1'b0, us_accum_reg} + {1'b0, tick_frac_us_reg};
        if (us_sum >= US_TWO_MS)
        begin
            us_wrap  = 10'(us_sum - US_TWO_MS);
            ms_carry = 2'd2;
        end
        else if (us_sum >= US_PER_MS)
        begin
            us_wrap  = 10'(us_sum - US_PER_MS);
            ms_carry = 2'd1;
        end
        else
        begin
            us_wrap  = us_sum[9:0];
            ms_carry = 2'd0;
        end
        ms_sum = {1'b0, ms_accum_reg} + 17'(tick_whole_ms_reg) + 17'(ms_carry);

        sec_v             = sec_count_reg;
        min_v             = min_count_reg;
        hour_v            = hour_count_reg;
        last_buttons_next = last_buttons_reg;
        us_accum_next     = us_accum_reg;
        btn               = buttons_reg & BUTTON_MASK;

        if (func_reg)
        begin
            // Bump one counter on a button change, seconds first
            ms_base = ms_accum_reg;
            if ((last_buttons_reg ^ btn) != 3'd0)
            begin
                last_buttons_next = btn;
                if (btn[0])
                    sec_v = sec_v + 8'd1;
                else if (btn[1])
                    min_v = min_v + 8'd1;
                else if (btn[2])
                    hour_v = hour_v + 8'd1;
            end
        end
        else
        begin
            // Saturate the millisecond sum
            ms_base       = ms_sum[16] ? 16'hFFFF : ms_sum[15:0];
            us_accum_next = us_wrap;
        end

        // Advance one second when the accumulator is full
        elapsed_next = (ms_base >= ms_per_second_reg);
        if (elapsed_next)
        begin
            ms_accum_next = ms_base - ms_per_second_reg;
            sec_v = sec_v + 8'd1;
            if (sec_v >= SEC_PER_MIN)
            begin
                sec_v = sec_v - SEC_PER_MIN;
                min_v = min_v + 8'd1;
            end
            if (min_v >= MIN_PER_HOUR)
            begin
                min_v  = min_v - MIN_PER_HOUR;
                hour_v = hour_v + 8'd1;
            end
            if (hour_v >= HOUR_PER_DAY)
                hour_v = 8'd0;
        end
        else
        begin
            ms_accum_next = ms_base;
        end

        sec_count_next  = sec_v;
        min_count_next  = min_v;
        hour_count_next = hour_v;
    end

    // Clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_accum_reg     <= 16'd0;
            us_accum_reg     <= 10'd0;
            sec_count_reg    <= 8'd0;
            min_count_reg    <= 8'd0;
            hour_count_reg   <= 8'd0;
            last_buttons_reg <= 3'd0;
        end
        else if (fire)
        begin
            ms_accum_reg     <= ms_accum_next;
            us_accum_reg     <= us_accum_next;
            sec_count_reg    <= sec_count_next;
            min_count_reg    <= min_count_next;
            hour_count_reg   <= hour_count_next;
            last_buttons_reg <= last_buttons_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            elapsed_reg <= elapsed_next;
            hours_reg   <= hour_count_next;
            minutes_reg <= min_count_next;
            seconds_reg <= sec_count_next;
        end
    end

    // Decimal digits of the result beat
    hms_digits u_hour_digits   (.value(hours_reg),   .digits(hour_digits));
    hms_digits u_minute_digits (.value(minutes_reg), .digits(minute_digits));
    hms_digits u_second_digits (.value(seconds_reg), .digits(second_digits));

    assign second_elapsed = elapsed_reg;
    assign hours          = hours_reg;
    assign minutes        = minutes_reg;
    assign seconds        = seconds_reg;
    assign hour_tens      = hour_digits.tens;
    assign hour_ones      = hour_digits.ones;
    assign minute_tens    = minute_digits.tens;
    assign minute_ones    = minute_digits.ones;
    assign second_tens    = second_digits.tens;
    assign second_ones    = second_digits.ones;

    // Checks
    `HMS_ASSERT_NOW(a_us_below_ms, 1'b1, us_accum_reg < US_PER_MS)
    `HMS_ASSERT_NOW(a_hours_wrap, out_valid_reg && elapsed_reg, hours_reg < HOUR_PER_DAY)
    `HMS_ASSERT_NEXT(a_fire_loads_result, fire, out_valid_reg)
    `HMS_ASSERT_NEXT(a_held_beat_kept, in_valid_reg && !fire, in_valid_reg)
    `HMS_ASSERT_NEXT(a_tick_keeps_buttons, fire && !func_reg, $stable(last_buttons_reg))

endmodule

### tb/hms_clock_checker.sv
module hms_clock_checker
    import hms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        func,
    input  logic [2:0]  buttons,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        second_elapsed,
    input  logic [7:0]  hours,
    input  logic [7:0]  minutes,
    input  logic [7:0]  seconds,
    input  logic [3:0]  hour_tens,
    input  logic [3:0]  hour_ones,
    input  logic [3:0]  minute_tens,
    input  logic [3:0]  minute_ones,
    input  logic [3:0]  second_tens,
    input  logic [3:0]  second_ones,
    output int          mismatches,
    output int          awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    // One result beat: counters plus their decimal digits
    typedef struct packed {
        logic        elapsed;
        logic [7:0]  hh;
        logic [7:0]  mm;
        logic [7:0]  ss;
        hms_digits_t hd;
        hms_digits_t md;
        hms_digits_t sd;
    } clock_reading_t;

    // Shadow copy of the registers
    logic [7:0]  whole_ms;
    logic [9:0]  frac_us;
    logic [15:0] second_len;

    // Shadow copy of the clock state
    logic [15:0] ms_acc;
    logic [9:0]  us_acc;
    logic [7:0]  sec_cnt;
    logic [7:0]  min_cnt;
    logic [7:0]  hour_cnt;
    logic [2:0]  prev_buttons;

    clock_reading_t pending_readings[$];

    function automatic hms_digits_t to_digits(input logic [7:0] v);
        hms_digits_t d;
        d.tens = 4'((v / 10) % 10);
        d.ones = 4'(v % 10);
        return d;
    endfunction

    // Apply one input beat to the shadow clock and return the reading it yields
    task automatic advance_clock(input logic f, input logic [2:0] b,
                                 output clock_reading_t r);
        int us;
        int ms;
        r.elapsed = 1'b0;
        if (f) begin
            // Bump one counter on a button change, seconds first
            if (((b ^ prev_buttons) & BUTTON_MASK) != 3'b000) begin
                prev_buttons = b & BUTTON_MASK;
                if (b[0])
                    sec_cnt = sec_cnt + 8'd1;
                else if (b[1])
                    min_cnt = min_cnt + 8'd1;
                else if (b[2])
                    hour_cnt = hour_cnt + 8'd1;
            end
        end else begin
            // Accumulate the tick, carry whole milliseconds out of the us part
            us = us_acc + frac_us;
            ms = ms_acc + whole_ms;
            if (us >= US_TWO_MS) begin
                us = us - US_TWO_MS;
                ms = ms + 2;
            end else if (us >= US_PER_MS) begin
                us = us - US_PER_MS;
                ms = ms + 1;
            end
            if (ms > 'hFFFF)
                ms = 'hFFFF;
            us_acc = us[9:0];
            ms_acc = ms[15:0];
        end
        // Take off one second and roll the counters
        if (ms_acc >= second_len) begin
            ms_acc = ms_acc - second_len;
            r.elapsed = 1'b1;
            sec_cnt = sec_cnt + 8'd1;
            if (sec_cnt >= SEC_PER_MIN) begin
                sec_cnt = sec_cnt - SEC_PER_MIN;
                min_cnt = min_cnt + 8'd1;
            end
            if (min_cnt >= MIN_PER_HOUR) begin
                min_cnt = min_cnt - MIN_PER_HOUR;
                hour_cnt = hour_cnt + 8'd1;
            end
            if (hour_cnt >= HOUR_PER_DAY)
                hour_cnt = 8'd0;
        end
        r.hh = hour_cnt;
        r.mm = min_cnt;
        r.ss = sec_cnt;
        r.hd = to_digits(hour_cnt);
        r.md = to_digits(min_cnt);
        r.sd = to_digits(sec_cnt);
    endtask

    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            if (mismatches < 10)
                $display("checker: %s mismatch at %0t, expected %0d, got %0d",
                         label, $time, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    // Track register writes, predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n) begin
        clock_reading_t want;
        clock_reading_t got;
        if (!rst_n) begin
            whole_ms = TICK_WHOLE_MS_RST;
            frac_us = TICK_FRAC_US_RST;
            second_len = MS_PER_SECOND_RST;
            ms_acc = '0;
            us_acc = '0;
            sec_cnt = '0;
            min_cnt = '0;
            hour_cnt = '0;
            prev_buttons = '0;
            pending_readings.delete();
            mismatches = 0;
            awaiting = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_TICK_WHOLE_MS: whole_ms = pwdata[7:0];
                    REG_TICK_FRAC_US:  frac_us = pwdata[9:0];
                    REG_MS_PER_SECOND: second_len = pwdata[15:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                got.elapsed = second_elapsed;
                got.hh = hours;
                got.mm = minutes;
                got.ss = seconds;
                got.hd = {hour_tens, hour_ones};
                got.md = {minute_tens, minute_ones};
                got.sd = {second_tens, second_ones};
                if (pending_readings.size() == 0) begin
                    if (mismatches < 10)
                        $display("checker: result beat with nothing pending at %0t",
                                 $time);
                    mismatches = mismatches + 1;
                end else begin
                    want = pending_readings.pop_front();
                    check_field("second_elapsed", want.elapsed, got.elapsed);
                    check_field("hours", want.hh, got.hh);
                    check_field("minutes", want.mm, got.mm);
                    check_field("seconds", want.ss, got.ss);
                    check_field("hour_tens", want.hd.tens, got.hd.tens);
                    check_field("hour_ones", want.hd.ones, got.hd.ones);
                    check_field("minute_tens", want.md.tens, got.md.tens);
                    check_field("minute_ones", want.md.ones, got.md.ones);
                    check_field("second_tens", want.sd.tens, got.sd.tens);
                    check_field("second_ones", want.sd.ones, got.sd.ones);
                end
            end
            if (in_valid && in_ready) begin
                advance_clock(func, buttons, want);
                pending_readings.push_back(want);
            end
            awaiting = pending_readings.size();
        end
    end

endmodule

### tb/testbench.sv
module testbench
    import hms_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Register index with no register behind it
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [2:0]  buttons;
    logic        out_valid;
    logic        out_ready;
    logic        second_elapsed;
    logic [7:0]  hours;
    logic [7:0]  minutes;
    logic [7:0]  seconds;
    logic [3:0]  hour_tens;
    logic [3:0]  hour_ones;
    logic [3:0]  minute_tens;
    logic [3:0]  minute_ones;
    logic [3:0]  second_tens;
    logic [3:0]  second_ones;
    int          mismatches;
    int          awaiting;

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    bit stall_toggle = 1'b0;
    logic [2:0] held_buttons = 3'b000;

    hms_clock_with_set_buttons i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .buttons(buttons),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .second_elapsed(second_elapsed),
        .hours(hours),
        .minutes(minutes),
        .seconds(seconds),
        .hour_tens(hour_tens),
        .hour_ones(hour_ones),
        .minute_tens(minute_tens),
        .minute_ones(minute_ones),
        .second_tens(second_tens),
        .second_ones(second_ones)
    );

    hms_clock_checker i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .pready(pready),
        .paddr(paddr),
        .pwdata(pwdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .buttons(buttons),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .second_elapsed(second_elapsed),
        .hours(hours),
        .minutes(minutes),
        .seconds(seconds),
        .hour_tens(hour_tens),
        .hour_ones(hour_ones),
        .minute_tens(minute_tens),
        .minute_ones(minute_ones),
        .second_tens(second_tens),
        .second_ones(second_ones),
        .mismatches(mismatches),
        .awaiting(awaiting)
    );

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Give up on a hung run
    initial
    begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Result side: random back-pressure plus one long hold-off on request
    initial
    begin
        int hold_left;
        bit seen_toggle;
        hold_left = 0;
        seen_toggle = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_toggle != seen_toggle)
            begin
                seen_toggle = stall_toggle;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Offer one input beat, with a random gap ahead of it, and hold it until taken
    task automatic send_beat(input logic f, input logic [2:0] b);
        if ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_gap_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        buttons <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait for every pending result to drain
    task automatic drain;
        in_valid <= 1'b0;
        @(negedge clk);
        while (awaiting != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup and access phase, then the bus returns to idle
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_rate(input int whole, input int frac, input int len);
        drain();
        write_register(REG_TICK_WHOLE_MS, whole);
        write_register(REG_TICK_FRAC_US, frac);
        write_register(REG_MS_PER_SECOND, len);
    endtask

    // Mostly press/release pairs on the buttons mixed with ticks
    task automatic run_mix(input int count, input int tick_pct);
        logic [2:0] b;
        repeat (count)
        begin
            if ($urandom_range(99) < tick_pct)
                send_beat(1'b0, 3'($urandom_range(7)));
            else
            begin
                if (held_buttons == 3'b000)
                    b = ($urandom_range(99) < 75) ? 3'(1 << $urandom_range(2))
                                                  : 3'($urandom_range(7));
                else
                    b = ($urandom_range(99) < 70) ? 3'b000 : 3'($urandom_range(7));
                held_buttons = b;
                send_beat(1'b1, b);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        func <= 1'b0;
        buttons <= 3'b000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one second every three ticks, every button and priority
        write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
        set_rate(1, 0, 3);
        send_beat(1'b0, 3'b111);
        send_beat(1'b0, 3'b000);
        send_beat(1'b0, 3'b010);
        send_beat(1'b1, 3'b001);
        send_beat(1'b1, 3'b000);
        send_beat(1'b1, 3'b010);
        send_beat(1'b1, 3'b000);
        send_beat(1'b1, 3'b100);
        send_beat(1'b1, 3'b111);
        send_beat(1'b1, 3'b111);
        send_beat(1'b1, 3'b110);
        send_beat(1'b1, 3'b101);
        send_beat(1'b1, 3'b011);
        send_beat(1'b1, 3'b000);
        send_beat(1'b0, 3'b101);
        send_beat(1'b1, 3'b100);
        send_beat(1'b0, 3'b000);
        send_beat(1'b0, 3'b000);
        send_beat(1'b1, 3'b000);

        // Zero second length with a fraction above 999: seconds on every beat
        set_rate(0, 1023, 0);
        send_gap_pct = 28;
        recv_gap_pct = 45;
        run_mix(150, 80);

        // Fast seconds, mixed buttons
        set_rate(1, 500, 3);
        run_mix(350, 60);

        // Largest ticks into the longest second: ms accumulator saturates
        set_rate(255, 999, 65535);
        send_gap_pct = 45;
        recv_gap_pct = 28;
        run_mix(320, 90);

        // Clock frozen; pump hours through its 8-bit wrap
        set_rate(0, 0, 65535);
        for (int i = 0; i < 520; i++)
            send_beat(1'b1, i[0] ? 3'b000 : 3'b100);

        // Full rate with a long result hold-off so the input stalls
        set_rate(200, 777, 1500);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        held_buttons = 3'b000;
        stall_toggle = ~stall_toggle;
        run_mix(400, 70);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/hms_pkg.sv
hdl/hms_digits.sv
hdl/hms_clock_with_set_buttons.sv
tb/hms_clock_checker.sv
tb/testbench.sv
